>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on a named clock, switched off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on the usual clock and reset of this project
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants of the double-ended ring queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 7;
  localparam int OCC_W          = 7;
  localparam int KIND_W         = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_e;

  typedef struct packed {
    logic             ok;
    logic             empty;
    logic             full;
    logic [OCC_W-1:0] occupancy;
  } status_t;

endpackage

>>> rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Channel interfaces of the double-ended ring queue: requests, results and
// the capacity write port.
// ----------------------------------------------------------------------------
interface deq_in_if #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic        [deq_pkg::KIND_W-1:0]  kind;
  logic signed [DATA_WIDTH-1:0]       data_word;

  modport source (output valid, kind, data_word, input ready);
  modport sink   (input valid, kind, data_word, output ready);
endinterface

interface deq_out_if #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [DATA_WIDTH-1:0]      front_value;
  logic signed [DATA_WIDTH-1:0]      rear_value;
  logic                              is_empty;
  logic                              is_full;
  logic        [deq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, accepted, front_value, rear_value, is_empty, is_full,
                  occupancy, input ready);
  modport sink   (input valid, accepted, front_value, rear_value, is_empty, is_full,
                  occupancy, output ready);
endinterface

interface deq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [deq_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/double_ended_ring_queue.sv
// ----------------------------------------------------------------------------
// double_ended_ring_queue
// Bounded double-ended queue of signed words in a ring memory.
// ----------------------------------------------------------------------------
// in_i carries one transaction per request: kind (push front, push rear,
// pop front, pop rear, query) and the word to push. out_o returns one result
// per request: accepted, front and rear words (all ones when empty), the
// empty and full flags and the occupancy after the operation. cfg_i writes
// the capacity (1 to DEPTH entries in use); write it only while the block is
// idle, it empties the queue.
// A request is taken in the idle state and its result is loaded into the output
// register from the lookup state: pointers move and the ring is written when the
// request is taken, front and rear are read back through the registered read of
// the ring memory in the lookup state. No new request is taken during the lookup.
// Reset empties the queue and sets the capacity to 64; the memory needs no
// clearing pass. When out_o stalls, a finished result waits in the output
// register, the next request is still taken and its lookup waits until the
// output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_ring_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  deq_in_if.sink          in_i,
  deq_out_if.source       out_o,
  deq_cfg_if.sink         cfg_i
);
  import deq_pkg::*;

  localparam int IdxW = $clog2(DEPTH);

  state_e                  state_q, state_d;
  logic                    in_fire, cfg_fire, load_out, in_ready;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr, rd_head, rd_tail;
  logic [DATA_WIDTH-1:0]   rd_front, rd_rear, front_w, rear_w;
  status_t                 status, status_q;
  logic                    fwd_front_q, fwd_rear_q;
  logic [DATA_WIDTH-1:0]   word_q;
  logic                    out_valid_q;
  logic                    out_accepted_q, out_empty_q, out_full_q;
  logic [DATA_WIDTH-1:0]   out_front_q, out_rear_q;
  logic [OCC_W-1:0]        out_occ_q;

  assign in_fire     = in_i.valid && in_ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_fire_i    (in_fire),
    .kind_i         (in_i.kind),
    .cfg_fire_i     (cfg_fire),
    .cfg_capacity_i (cfg_i.capacity),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .rd_head_o      (rd_head),
    .rd_tail_o      (rd_tail),
    .status_o       (status)
  );

  deq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (in_i.data_word),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (rd_head),
    .rd_addr_b_i (rd_tail),
    .rd_data_a_o (rd_front),
    .rd_data_b_o (rd_rear)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // the ring returns the old word when the entry is written in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status;
      fwd_front_q <= wr_en && (wr_addr == rd_head);
      fwd_rear_q  <= wr_en && (wr_addr == rd_tail);
      word_q      <= in_i.data_word;
    end
  end

  assign front_w = status_q.empty ? '1 : (fwd_front_q ? word_q : rd_front);
  assign rear_w  = status_q.empty ? '1 : (fwd_rear_q ? word_q : rd_rear);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_accepted_q <= status_q.ok;
      out_empty_q    <= status_q.empty;
      out_full_q     <= status_q.full;
      out_occ_q      <= status_q.occupancy;
      out_front_q    <= front_w;
      out_rear_q     <= rear_w;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = out_accepted_q;
  assign out_o.front_value = $signed(out_front_q);
  assign out_o.rear_value  = $signed(out_rear_q);
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;
  assign out_o.occupancy   = out_occ_q;

  `ASSERT_STD(a_fire_to_lookup, in_fire |=> state_q == ST_LOOKUP, "request not looked up")
  `ASSERT_STD(a_result_source, $rose(out_valid_q) |-> $past(state_q) == ST_LOOKUP, "result without request")
  `ASSERT_STD(a_no_take_in_lookup, state_q == ST_LOOKUP |-> !in_ready, "request taken during lookup")

endmodule

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]         rd_data_a_o,
  output logic [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q, rd_b_q;

  // read during write returns the old word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Head, tail, count and capacity registers; works out the ring write and the
// two read addresses of each transaction and the status after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_fire_i,
  input  logic [deq_pkg::KIND_W-1:0]  kind_i,
  input  logic                        cfg_fire_i,
  input  logic [deq_pkg::CAP_W-1:0]   cfg_capacity_i,
  output logic                        wr_en_o,
  output logic [$clog2(DEPTH)-1:0]    wr_addr_o,
  output logic [$clog2(DEPTH)-1:0]    rd_head_o,
  output logic [$clog2(DEPTH)-1:0]    rd_tail_o,
  output deq_pkg::status_t            status_o
);
  import deq_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CmpW = ((IdxW > CAP_W) ? IdxW : CAP_W) + 1;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  logic [CAP_W-1:0] cap_q;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0] count_q, count_d;
  logic [CmpW-1:0]  cap_eff, cap_x, head_x, tail_x, count_x;
  logic             full, empty, ok;

  function automatic logic [CmpW-1:0] idx_inc(input logic [CmpW-1:0] i,
                                              input logic [CmpW-1:0] cap);
    logic [CmpW-1:0] nxt;
    nxt = i + 1'b1;
    return (nxt >= cap) ? '0 : nxt;
  endfunction

  function automatic logic [CmpW-1:0] idx_dec(input logic [CmpW-1:0] i,
                                              input logic [CmpW-1:0] cap);
    return (i == '0 || i >= cap) ? cap - 1'b1 : i - 1'b1;
  endfunction

  // a capacity of zero acts as one, above the built depth as the depth
  always_comb begin
    cap_x = CmpW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_x > DepthC) begin
      cap_eff = DepthC;
    end else begin
      cap_eff = cap_x;
    end
  end

  assign head_x  = CmpW'(head_q);
  assign tail_x  = CmpW'(tail_q);
  assign count_x = CmpW'(count_q);
  assign full    = count_x >= cap_eff;
  assign empty   = count_q == '0;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ok        = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = head_q;
    case (kind_e'(kind_i))
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (!full) begin
          ok      = 1'b1;
          wr_en_o = item_fire_i;
          count_d = count_q + 1'b1;
          if (empty) begin
            head_d = '0;
            tail_d = '0;
          end else if (kind_e'(kind_i) == KIND_PUSH_FRONT) begin
            head_d = IdxW'(idx_dec(head_x, cap_eff));
          end else begin
            tail_d = IdxW'(idx_inc(tail_x, cap_eff));
          end
          wr_addr_o = (kind_e'(kind_i) == KIND_PUSH_FRONT || empty) ? head_d : tail_d;
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (!empty) begin
          ok      = 1'b1;
          count_d = count_q - 1'b1;
          // the last word leaves the indices where they are
          if (count_q > OCC_W'(1)) begin
            if (kind_e'(kind_i) == KIND_POP_FRONT) begin
              head_d = IdxW'(idx_inc(head_x, cap_eff));
            end else begin
              tail_d = IdxW'(idx_dec(tail_x, cap_eff));
            end
          end
        end
      end
      KIND_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign rd_head_o          = head_d;
  assign rd_tail_o          = tail_d;
  assign status_o.ok        = ok;
  assign status_o.empty     = count_d == '0;
  assign status_o.full      = CmpW'(count_d) >= cap_eff;
  assign status_o.occupancy = count_d;

  // a capacity write empties the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_fire_i) begin
      cap_q   <= cfg_capacity_i;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (item_fire_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  `ASSERT_STD(a_count_bound, count_x <= cap_eff, "occupancy above capacity")
  `ASSERT_STD(a_index_bound, head_x < cap_eff && tail_x < cap_eff, "ring index out of range")
  `ASSERT_STD(a_push_counts, item_fire_i && !cfg_fire_i && !full && (kind_i == KIND_PUSH_REAR || kind_i == KIND_PUSH_FRONT) |=> count_q == $past(count_q) + 1'b1, "push lost in count")
  `ASSERT_STD(a_cfg_clears, cfg_fire_i |=> count_q == '0 && head_q == '0 && tail_q == '0, "capacity write left words")

endmodule
